// ----- sv/bms_pkg.sv -----
`timescale 1ns / 1ps

package bms_pkg;

    // Table geometry and arithmetic widths
    localparam int ALPHABET    = 26;
    localparam int COUNT_BITS  = 32;
    localparam int RANDOM_BITS = 48;
    localparam int LIDX_W      = $clog2(ALPHABET);
    localparam int PAIRS       = ALPHABET * ALPHABET;
    localparam int ADDR_W      = $clog2(PAIRS);
    localparam int TOTAL_BITS  = COUNT_BITS + $clog2(ALPHABET);

    // Port field widths
    localparam int REQ_W        = 2;
    localparam int LETTER_W     = 5;
    localparam int PAIR_COUNT_W = 32;
    localparam int RANDOM_W     = 48;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NEXT  = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_TOT_RD,
        ST_TOT_CHK,
        ST_DIV,
        ST_WALK,
        ST_RESULT
    } state_t;

    // Access bundle for the count and row-total memories
    typedef struct packed {
        logic                  pc_we;
        logic [ADDR_W-1:0]     pc_waddr;
        logic [COUNT_BITS-1:0] pc_wdata;
        logic [ADDR_W-1:0]     pc_raddr;
        logic                  rt_we;
        logic [LIDX_W-1:0]     rt_waddr;
        logic [TOTAL_BITS-1:0] rt_wdata;
        logic [LIDX_W-1:0]     rt_raddr;
    } mem_req_t;

endpackage

// ----- sv/bms_mem.sv -----
`timescale 1ns / 1ps

module bms_mem (
    input  logic                             aclk,
    input  bms_pkg::mem_req_t                req,
    output logic [bms_pkg::COUNT_BITS-1:0]   pc_rdata,
    output logic [bms_pkg::TOTAL_BITS-1:0]   rt_rdata
);
    import bms_pkg::*;

    logic [COUNT_BITS-1:0] pair_mem [PAIRS];
    logic [TOTAL_BITS-1:0] total_mem [ALPHABET];
    logic [COUNT_BITS-1:0] pc_rdata_reg;
    logic [TOTAL_BITS-1:0] rt_rdata_reg;

    // Pair counts: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (req.pc_we) begin
            pair_mem[req.pc_waddr] <= req.pc_wdata;
        end
        pc_rdata_reg <= pair_mem[req.pc_raddr];
    end

    // Row totals: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (req.rt_we) begin
            total_mem[req.rt_waddr] <= req.rt_wdata;
        end
        rt_rdata_reg <= total_mem[req.rt_raddr];
    end

    assign pc_rdata = pc_rdata_reg;
    assign rt_rdata = rt_rdata_reg;

endmodule

// ----- sv/bms_mod_unit.sv -----
`timescale 1ns / 1ps

module bms_mod_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [bms_pkg::RANDOM_BITS-1:0]   dividend,
    input  logic [bms_pkg::TOTAL_BITS-1:0]    divisor,
    output logic                              done,
    output logic [bms_pkg::TOTAL_BITS-1:0]    remainder
);
    import bms_pkg::*;

    localparam int CNT_W = $clog2(RANDOM_BITS);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [RANDOM_BITS-1:0] dvd_reg, dvd_next;
    logic [TOTAL_BITS-1:0]  dvs_reg, dvs_next;
    logic [TOTAL_BITS-1:0]  rem_reg, rem_next;
    logic [TOTAL_BITS:0]    shifted;

    // Restoring remainder, one dividend bit per cycle
    always_comb begin
        shifted   = {rem_reg, dvd_reg[RANDOM_BITS-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[RANDOM_BITS-2:0], 1'b0};
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = TOTAL_BITS'(shifted - {1'b0, dvs_reg});
            end else begin
                rem_next = TOTAL_BITS'(shifted);
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(RANDOM_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    // Done is a single-cycle pulse at the end of a run
    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |=> !done_reg)
        else $error("mod unit done held for more than one cycle");
    // Remainder stays below the divisor once a run completes
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg && (dvs_reg != '0) |-> rem_reg < dvs_reg)
        else $error("mod unit remainder not reduced");

endmodule

// ----- sv/bigram_markov_letter_sampler_top.sv -----
`timescale 1ns / 1ps

// Load: old pair count and row total read, then new count and corrected row total written.
// Start: random value reduced modulo the alphabet size. Next: row total read, remainder by the
// row total, then a pipelined walk over the row, one pair-count memory read per letter; an
// empty row skips remainder and walk. One transaction is worked at a time; a finished result
// waits in the output register. After reset a clearing pass zeroes both memories, s_ready low.
module bigram_markov_letter_sampler_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bms_pkg::REQ_W-1:0]          s_req_type,
    input  logic [bms_pkg::LETTER_W-1:0]       s_row_letter,
    input  logic [bms_pkg::LETTER_W-1:0]       s_col_letter,
    input  logic [bms_pkg::PAIR_COUNT_W-1:0]   s_pair_count,
    input  logic [bms_pkg::RANDOM_W-1:0]       s_random_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bms_pkg::LETTER_W-1:0]       m_letter,
    output logic                               m_row_empty
);
    import bms_pkg::*;

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      clr_idx_reg, clr_idx_next;
    logic [REQ_W-1:0]       req_reg, req_next;
    logic [LIDX_W-1:0]      row_reg, row_next;
    logic [ADDR_W-1:0]      pair_idx_reg, pair_idx_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [RANDOM_BITS-1:0] rnd_reg, rnd_next;
    logic [LIDX_W-1:0]      cur_letter_reg, cur_letter_next;
    logic [ADDR_W-1:0]      base_reg, base_next;
    logic [TOTAL_BITS-1:0]  r_reg, r_next;
    logic [LIDX_W:0]        walk_idx_reg, walk_idx_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [LIDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [LIDX_W-1:0]      pick_reg, pick_next;
    logic                   empty_reg, empty_next;
    logic                   m_valid_reg, m_valid_next;
    logic [LETTER_W-1:0]    m_letter_reg, m_letter_next;
    logic                   m_empty_reg, m_empty_next;

    mem_req_t               mreq;
    logic [COUNT_BITS-1:0]  pc_rdata;
    logic [TOTAL_BITS-1:0]  rt_rdata;

    logic                   div_start;
    logic [RANDOM_BITS-1:0] div_dividend;
    logic [TOTAL_BITS-1:0]  div_divisor;
    logic                   div_done;
    logic [TOTAL_BITS-1:0]  div_rem;

    logic                   load_ok;
    logic                   out_free;
    logic                   hit;
    logic                   last_cmp;

    bms_mem u_mem (
        .aclk     (aclk),
        .req      (mreq),
        .pc_rdata (pc_rdata),
        .rt_rdata (rt_rdata)
    );

    bms_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Shared terms
    assign load_ok  = (s_row_letter < LETTER_W'(ALPHABET)) &&
                      (s_col_letter < LETTER_W'(ALPHABET));
    assign out_free = !m_valid_reg || m_ready;
    assign hit      = r_reg < TOTAL_BITS'(pc_rdata);
    assign last_cmp = cmp_idx_reg == LIDX_W'(ALPHABET - 1);
    assign s_ready  = (state_reg == ST_IDLE);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_idx_reg == ADDR_W'(PAIRS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_req_type)
                        REQ_LOAD:  state_next = load_ok ? ST_LOAD_RD : ST_IDLE;
                        REQ_START: state_next = ST_DIV;
                        REQ_NEXT:  state_next = ST_TOT_RD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD_RD: state_next = ST_LOAD_WR;
            ST_LOAD_WR: state_next = ST_IDLE;
            ST_TOT_RD:  state_next = ST_TOT_CHK;
            ST_TOT_CHK: state_next = (rt_rdata == '0) ? ST_RESULT : ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    state_next = (req_reg == REQ_START) ? ST_RESULT : ST_WALK;
                end
            end
            ST_WALK: begin
                if (cmp_vld_reg && (hit || last_cmp)) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Datapath, memory access and remainder unit control
    always_comb begin
        clr_idx_next    = clr_idx_reg;
        req_next        = req_reg;
        row_next        = row_reg;
        pair_idx_next   = pair_idx_reg;
        cnt_next        = cnt_reg;
        rnd_next        = rnd_reg;
        cur_letter_next = cur_letter_reg;
        base_next       = base_reg;
        r_next          = r_reg;
        walk_idx_next   = walk_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        pick_next       = pick_reg;
        empty_next      = empty_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_letter_next   = m_letter_reg;
        m_empty_next    = m_empty_reg;
        mreq            = '0;
        div_start       = 1'b0;
        div_dividend    = rnd_reg;
        div_divisor     = rt_rdata;

        unique case (state_reg)
            ST_CLEAR: begin
                mreq.pc_we    = 1'b1;
                mreq.pc_waddr = clr_idx_reg;
                mreq.rt_we    = (clr_idx_reg < ADDR_W'(ALPHABET));
                mreq.rt_waddr = LIDX_W'(clr_idx_reg);
                clr_idx_next  = clr_idx_reg + 1'b1;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next      = s_req_type;
                    row_next      = LIDX_W'(s_row_letter);
                    pair_idx_next = ADDR_W'(ADDR_W'(s_row_letter) * ADDR_W'(ALPHABET)
                                    + ADDR_W'(s_col_letter));
                    cnt_next      = s_pair_count[COUNT_BITS-1:0];
                    rnd_next      = s_random_value[RANDOM_BITS-1:0];
                    base_next     = ADDR_W'(ADDR_W'(cur_letter_reg) * ADDR_W'(ALPHABET));
                    empty_next    = 1'b0;
                    // first-letter draw reduces modulo the alphabet size
                    div_start     = (s_req_type == REQ_START);
                    div_dividend  = s_random_value[RANDOM_BITS-1:0];
                    div_divisor   = TOTAL_BITS'(ALPHABET);
                end
            end
            ST_LOAD_RD: begin
                mreq.pc_raddr = pair_idx_reg;
                mreq.rt_raddr = row_reg;
            end
            ST_LOAD_WR: begin
                // row total corrected by the difference of old and new count
                mreq.pc_we    = 1'b1;
                mreq.pc_waddr = pair_idx_reg;
                mreq.pc_wdata = cnt_reg;
                mreq.rt_we    = 1'b1;
                mreq.rt_waddr = row_reg;
                mreq.rt_wdata = rt_rdata - TOTAL_BITS'(pc_rdata) + TOTAL_BITS'(cnt_reg);
            end
            ST_TOT_RD: begin
                mreq.rt_raddr = cur_letter_reg;
            end
            ST_TOT_CHK: begin
                if (rt_rdata == '0) begin
                    empty_next = 1'b1;
                    pick_next  = '0;
                end else begin
                    div_start = 1'b1;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    pick_next     = LIDX_W'(div_rem);
                    r_next        = div_rem;
                    walk_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                end
            end
            ST_WALK: begin
                // issue one row entry per cycle; compare the entry read last cycle
                if (walk_idx_reg < (LIDX_W + 1)'(ALPHABET)) begin
                    mreq.pc_raddr = base_reg + ADDR_W'(walk_idx_reg);
                    walk_idx_next = walk_idx_reg + 1'b1;
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = LIDX_W'(walk_idx_reg);
                end else begin
                    cmp_vld_next = 1'b0;
                end
                if (cmp_vld_reg) begin
                    if (hit) begin
                        pick_next = cmp_idx_reg;
                    end else if (last_cmp) begin
                        pick_next = '0;
                    end else begin
                        r_next = r_reg - TOTAL_BITS'(pc_rdata);
                    end
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_letter_next = LETTER_W'(pick_reg);
                    m_empty_next  = empty_reg;
                    if (!empty_reg) begin
                        cur_letter_next = pick_reg;
                    end
                end
            end
            default: begin
                mreq = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            cur_letter_reg <= '0;
            cmp_vld_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            cur_letter_reg <= cur_letter_next;
            cmp_vld_reg    <= cmp_vld_next;
            m_valid_reg    <= m_valid_next;
        end
        req_reg      <= req_next;
        row_reg      <= row_next;
        pair_idx_reg <= pair_idx_next;
        cnt_reg      <= cnt_next;
        rnd_reg      <= rnd_next;
        base_reg     <= base_next;
        r_reg        <= r_next;
        walk_idx_reg <= walk_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        pick_reg     <= pick_next;
        empty_reg    <= empty_next;
        m_letter_reg <= m_letter_next;
        m_empty_reg  <= m_empty_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_letter    = m_letter_reg;
    assign m_row_empty = m_empty_reg;

    // A drawn letter always lies inside the alphabet
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_row_empty |-> m_letter < LETTER_W'(ALPHABET))
        else $error("drawn letter outside alphabet");
    // Empty-row result carries letter zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_row_empty |-> m_letter == '0)
        else $error("empty-row result with nonzero letter");
    // Remainder unit finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("remainder done outside of DIV");
    // An empty-row result leaves the current letter unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RESULT && out_free && empty_reg |=> $stable(cur_letter_reg))
        else $error("current letter changed on empty row");

endmodule

// ----- tb/tb_bigram_markov_letter_sampler_top.sv -----
`timescale 1ns / 1ps

module tb_bigram_markov_letter_sampler_top;
    import bms_pkg::*;

    // Request code the block drops without a result
    localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;
    localparam int               DRAIN_CYCLES = 150;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [LETTER_W-1:0]     row_letter;
        logic [LETTER_W-1:0]     col_letter;
        logic [PAIR_COUNT_W-1:0] pair_count;
        logic [RANDOM_W-1:0]     random_value;
    } sampler_req_t;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                row_empty;
    } drawn_letter_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [REQ_W-1:0]        s_req_type = '0;
    logic [LETTER_W-1:0]     s_row_letter = '0;
    logic [LETTER_W-1:0]     s_col_letter = '0;
    logic [PAIR_COUNT_W-1:0] s_pair_count = '0;
    logic [RANDOM_W-1:0]     s_random_value = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [LETTER_W-1:0]     m_letter;
    logic                    m_row_empty;

    bigram_markov_letter_sampler_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_row_letter   (s_row_letter),
        .s_col_letter   (s_col_letter),
        .s_pair_count   (s_pair_count),
        .s_random_value (s_random_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_letter       (m_letter),
        .m_row_empty    (m_row_empty)
    );

    // Mirror of the bigram table, row sums and the current letter
    logic [COUNT_BITS-1:0] pair_table [PAIRS];
    logic [TOTAL_BITS-1:0] row_sums [ALPHABET];
    logic [LETTER_W-1:0]   chain_letter;

    sampler_req_t  pending_reqs[$];
    drawn_letter_t expected_draws[$];
    int            reqs_total;
    int            reqs_accepted;
    int            error_count;
    int            send_gap;
    int            recv_stall;
    bit            calm_phase;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Idling is off during calm stretches and over the tail of the run
    function automatic bit idling_on();
        return !calm_phase && (pending_reqs.size() > 100);
    endfunction

    function automatic logic [RANDOM_W-1:0] rand_draw_bits();
        logic [15:0] hi;
        logic [31:0] lo;
        hi = 16'($urandom_range(0, 16'hFFFF));
        lo = $urandom();
        return {hi, lo};
    endfunction

    function automatic logic [PAIR_COUNT_W-1:0] rand_pair_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) return '0;
        if (pick < 50) return PAIR_COUNT_W'($urandom_range(1, 9));
        if (pick < 75) return PAIR_COUNT_W'($urandom_range(1, 1000));
        if (pick < 95) return $urandom();
        return '1;
    endfunction

    task automatic queue_req(input logic [REQ_W-1:0] req, input int row, input int col,
                             input logic [PAIR_COUNT_W-1:0] cnt,
                             input logic [RANDOM_W-1:0] rnd);
        sampler_req_t r;
        r.req_type     = req;
        r.row_letter   = LETTER_W'(row);
        r.col_letter   = LETTER_W'(col);
        r.pair_count   = cnt;
        r.random_value = rnd;
        pending_reqs.push_back(r);
    endtask

    // Apply one accepted transaction to the mirror and queue its draw, if any
    function automatic void predict_draw(input sampler_req_t r);
        drawn_letter_t d;
        int            idx;
        int            cur;
        logic [RANDOM_W-1:0]   rem;
        logic [TOTAL_BITS-1:0] sum;
        bit            found;
        d = '0;
        case (r.req_type)
            REQ_LOAD: begin
                if (r.row_letter < ALPHABET && r.col_letter < ALPHABET) begin
                    idx = int'(r.row_letter) * ALPHABET + int'(r.col_letter);
                    row_sums[r.row_letter] = row_sums[r.row_letter] - pair_table[idx]
                                             + r.pair_count;
                    pair_table[idx] = r.pair_count;
                end
            end
            REQ_START: begin
                rem = r.random_value % RANDOM_W'(ALPHABET);
                chain_letter = LETTER_W'(rem);
                d.letter = chain_letter;
                expected_draws.push_back(d);
            end
            REQ_NEXT: begin
                cur = int'(chain_letter) % ALPHABET;
                sum = row_sums[cur];
                if (sum == '0) begin
                    // empty row: flag only, chain stays where it is
                    d.row_empty = 1'b1;
                end else begin
                    rem = r.random_value % RANDOM_W'(sum);
                    found = 1'b0;
                    for (int j = 0; j < ALPHABET; j++) begin
                        if (!found) begin
                            if (rem < pair_table[cur * ALPHABET + j]) begin
                                d.letter = LETTER_W'(j);
                                found = 1'b1;
                            end else begin
                                rem = rem - pair_table[cur * ALPHABET + j];
                            end
                        end
                    end
                    chain_letter = d.letter;
                end
                expected_draws.push_back(d);
            end
            default: ;
        endcase
    endfunction

    // Input driver
    always @(posedge aclk) begin
        sampler_req_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_draw({s_req_type, s_row_letter, s_col_letter, s_pair_count,
                              s_random_value});
                reqs_accepted++;
                if (reqs_accepted % 64 == 0)
                    calm_phase = ($urandom_range(0, 3) == 0);
                if (idling_on() && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 13);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    r = pending_reqs.pop_front();
                    s_valid        <= 1'b1;
                    s_req_type     <= r.req_type;
                    s_row_letter   <= r.row_letter;
                    s_col_letter   <= r.col_letter;
                    s_pair_count   <= r.pair_count;
                    s_random_value <= r.random_value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result-side backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_ready <= 1'b0;
        end else if (idling_on() && $urandom_range(0, 7) == 0) begin
            recv_stall = $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        drawn_letter_t d;
        if (aresetn && m_valid && m_ready) begin
            if (expected_draws.size() == 0) begin
                $error("unexpected result: letter %0d row_empty %0d", m_letter, m_row_empty);
                error_count++;
            end else begin
                d = expected_draws.pop_front();
                if (m_letter !== d.letter) begin
                    $error("letter: expected %0d, got %0d", d.letter, m_letter);
                    error_count++;
                end
                if (m_row_empty !== d.row_empty) begin
                    $error("row_empty: expected %0d, got %0d", d.row_empty, m_row_empty);
                    error_count++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int pick;
        int row;
        int col;
        for (int i = 0; i < PAIRS; i++) pair_table[i] = '0;
        for (int i = 0; i < ALPHABET; i++) row_sums[i] = '0;
        chain_letter  = '0;
        reqs_accepted = 0;
        error_count   = 0;
        send_gap      = 0;
        recv_stall    = 0;
        calm_phase    = 1'b0;

        // Directed: empty row, start extremes, single-entry row, wide row sums
        queue_req(REQ_NEXT, 0, 0, '0, '0);
        queue_req(REQ_START, 0, 0, '0, '0);
        queue_req(REQ_START, 31, 31, '1, '1);
        queue_req(REQ_LOAD, 0, 25, 1, '1);
        queue_req(REQ_LOAD, 0, 0, 0, '0);
        queue_req(REQ_START, 0, 0, '0, RANDOM_W'(26));
        queue_req(REQ_NEXT, 0, 0, '0, '1);
        queue_req(REQ_NEXT, 0, 0, '0, '0);
        queue_req(REQ_LOAD, 25, 0, '1, '0);
        queue_req(REQ_LOAD, 25, 12, '1, '0);
        queue_req(REQ_LOAD, 25, 25, '1, '0);
        queue_req(REQ_NEXT, 0, 0, '0, '1);
        queue_req(REQ_START, 0, 0, '0, RANDOM_W'(25));
        queue_req(REQ_NEXT, 0, 0, '0, '0);
        queue_req(REQ_LOAD, 25, 12, 0, '1);
        queue_req(REQ_START, 0, 0, '0, RANDOM_W'(25));
        queue_req(REQ_NEXT, 0, 0, '0, rand_draw_bits());
        // loads outside the table and the unused code are dropped
        queue_req(REQ_LOAD, 31, 3, '1, '0);
        queue_req(REQ_LOAD, 3, 31, '1, '0);
        queue_req(REQ_LOAD, 26, 26, '1, '0);
        queue_req(REQ_IGNORED, 31, 31, '1, '1);
        queue_req(REQ_START, 0, 0, '0, RANDOM_W'(25));
        queue_req(REQ_NEXT, 0, 0, '0, RANDOM_W'(32'hFFFF_FFFF) + 1);

        // Random: table fills, chains of draws, some noise
        for (int n = 0; n < 830; n++) begin
            pick = $urandom_range(0, 99);
            row  = $urandom_range(0, ALPHABET - 1);
            col  = $urandom_range(0, ALPHABET - 1);
            if (pick < 35) begin
                queue_req(REQ_LOAD, row, col, rand_pair_count(), rand_draw_bits());
            end else if (pick < 45) begin
                queue_req(REQ_START, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom(), rand_draw_bits());
            end else if (pick < 95) begin
                queue_req(REQ_NEXT, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom(), rand_draw_bits());
            end else if (pick < 97) begin
                queue_req(REQ_IGNORED, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom(), rand_draw_bits());
            end else if (pick < 98) begin
                queue_req(REQ_LOAD, $urandom_range(ALPHABET, 31), $urandom_range(0, 31),
                          $urandom(), rand_draw_bits());
            end else begin
                queue_req(REQ_LOAD, row, $urandom_range(ALPHABET, 31), $urandom(),
                          rand_draw_bits());
            end
        end
        reqs_total = pending_reqs.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (reqs_accepted < reqs_total) @(posedge aclk);
        while (expected_draws.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
